// File: src/crbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbe_pkg: shared types and constants of the clipmap ring block emitter
// Holds the beat types of both channels, the command passed from the front
// end to the back end, register addresses and the fixed datapath widths.
// ----------------------------------------------------------------------------
package crbe_pkg;

	// Default values of the top level parameters.
	localparam int SIDE_BLOCKS_DEF = 4;
	localparam int MAX_LEVELS_DEF  = 16;
	localparam int CMD_DEPTH_DEF   = 2;

	// Fixed datapath widths.
	localparam int CAM_W   = 32;
	localparam int LEVEL_W = 4;
	localparam int OFS_W   = 48;
	localparam int SCALE_W = 31;
	localparam int BWS_W   = 39;
	localparam int POS_W   = 50;
	localparam int CNT_W   = 7;
	localparam int STEP_W  = 5;
	localparam int BSIZE_W = 8;
	localparam int RES_W   = 16;

	// Register reset values.
	localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = 8'd32;
	localparam logic [RES_W-1:0]   RESOLUTION_RST = 16'd256;

	// Register index, taken from paddr[2].
	localparam logic REG_BLOCK_SIZE = 1'b0;
	localparam logic REG_RESOLUTION = 1'b1;

	// Input beat.
	typedef struct packed {
		logic signed [CAM_W-1:0] cam_x;
		logic signed [CAM_W-1:0] cam_z;
		logic [LEVEL_W-1:0]      level;
	} item_t;

	// Output beat.
	typedef struct packed {
		logic signed [OFS_W-1:0] offset_x;
		logic signed [OFS_W-1:0] offset_z;
		logic [SCALE_W-1:0]      block_scale;
		logic [LEVEL_W-1:0]      out_level;
		logic                    last;
		logic [CNT_W-1:0]        level_block_count;
	} blk_t;

	// One level's walk, as prepared by the front end.
	typedef struct packed {
		logic signed [POS_W-1:0] start_x;
		logic signed [POS_W-1:0] start_z;
		logic signed [POS_W-1:0] bws;
		logic signed [POS_W-1:0] fmin_x;
		logic signed [POS_W-1:0] fmax_x;
		logic signed [POS_W-1:0] fmin_z;
		logic signed [POS_W-1:0] fmax_z;
		logic                    skip_en;
		logic [SCALE_W-1:0]      scale;
		logic [LEVEL_W-1:0]      level;
	} cmd_t;

endpackage

// File: src/crbe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbe_front: register file, snap divider and command builder
// Takes one camera beat, snaps it to the level's block grid with a serial
// remainder divider and builds the walk command for the back end.
// ----------------------------------------------------------------------------
module crbe_front
	import crbe_pkg::*;
#(
	parameter int SIDE_BLOCKS = SIDE_BLOCKS_DEF,
	parameter int MAX_LEVELS  = MAX_LEVELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         item_valid,
	output logic         item_stall,
	input  item_t        item,
	output logic         cmd_push,
	output cmd_t         cmd,
	input  logic         cmd_full
);

	localparam int HALF = SIDE_BLOCKS / 2;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCALE = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_ADJ   = 6'b001000,
		ST_SNAP  = 6'b010000,
		ST_PUSH  = 6'b100000
	} state_t;

	state_t state_q;

	logic [BSIZE_W-1:0]      block_size_q;
	logic [RES_W-1:0]        resolution_q;
	logic signed [CAM_W-1:0] cx_q, cz_q;
	logic [LEVEL_W-1:0]      lvl_q;
	logic [SCALE_W-1:0]      scale_q;
	logic [BWS_W-1:0]        bws_q;
	logic signed [POS_W-1:0] hb_q;
	logic [CAM_W-1:0]        ax_q, az_q;
	logic [BWS_W-1:0]        rx_q, rz_q;
	logic [BWS_W-1:0]        adjx_q, adjz_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [POS_W-1:0] sx_q, sz_q, emb_q;
	logic signed [OFS_W-1:0] fsx_q, fsz_q;

	logic                    wr_en;
	logic                    accept;
	logic [SCALE_W-1:0]      scale_nxt;
	logic [BWS_W:0]          tx, tz;
	logic signed [POS_W-1:0] ext, fsx_w, fsz_w;

	// Configuration port: pready is tied high, so accesses never wait.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_RESOLUTION) ? {16'b0, resolution_q} :
		{24'b0, block_size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BLOCK_SIZE_RST;
			resolution_q <= RESOLUTION_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_BLOCK_SIZE: block_size_q <= pwdata[BSIZE_W-1:0];
				REG_RESOLUTION: resolution_q <= pwdata[RES_W-1:0];
				default:        block_size_q <= block_size_q;
			endcase
		end
	end

	// Input handshake: one item at a time.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	// Level cell size and one restoring step per axis.
	assign scale_nxt = SCALE_W'(resolution_q) << lvl_q;
	assign tx        = {rx_q, ax_q[CAM_W-1]};
	assign tz        = {rz_q, az_q[CAM_W-1]};

	// Finer footprint from the stored snap point.
	assign ext   = hb_q >>> 1;
	assign fsx_w = POS_W'(fsx_q);
	assign fsz_w = POS_W'(fsz_q);

	always_comb begin
		cmd.start_x = sx_q - hb_q;
		cmd.start_z = sz_q - hb_q;
		cmd.bws     = signed'(POS_W'(bws_q));
		cmd.fmin_x  = fsx_w - ext;
		cmd.fmax_x  = fsx_w + emb_q;
		cmd.fmin_z  = fsz_w - ext;
		cmd.fmax_z  = fsz_w + emb_q;
		cmd.skip_en = (lvl_q != '0);
		cmd.scale   = scale_q;
		cmd.level   = lvl_q;
	end

	assign cmd_push = (state_q == ST_PUSH) && !cmd_full;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			fsx_q   <= '0;
			fsz_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && ({1'b0, item.level} < (LEVEL_W+1)'(MAX_LEVELS))) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(CAM_W - 1)) begin
						state_q <= ST_ADJ;
					end
				end
				ST_ADJ: begin
					state_q <= ST_SNAP;
				end
				ST_SNAP: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!cmd_full) begin
						fsx_q   <= sx_q[OFS_W-1:0];
						fsz_q   <= sz_q[OFS_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q  <= item.cam_x;
			cz_q  <= item.cam_z;
			lvl_q <= item.level;
		end
		if (state_q == ST_SCALE) begin
			scale_q <= scale_nxt;
			bws_q   <= BWS_W'(block_size_q) * BWS_W'(scale_nxt);
			ax_q    <= cx_q[CAM_W-1] ? CAM_W'(-cx_q) : CAM_W'(cx_q);
			az_q    <= cz_q[CAM_W-1] ? CAM_W'(-cz_q) : CAM_W'(cz_q);
			rx_q    <= '0;
			rz_q    <= '0;
		end
		// One remainder bit per cycle on both axes.
		if (state_q == ST_DIV) begin
			hb_q <= signed'(POS_W'(bws_q) * POS_W'(HALF));
			ax_q <= ax_q << 1;
			az_q <= az_q << 1;
			rx_q <= (tx >= (BWS_W+1)'(bws_q)) ? BWS_W'(tx - (BWS_W+1)'(bws_q)) :
				tx[BWS_W-1:0];
			rz_q <= (tz >= (BWS_W+1)'(bws_q)) ? BWS_W'(tz - (BWS_W+1)'(bws_q)) :
				tz[BWS_W-1:0];
		end
		// Floored snap: a negative coordinate with a remainder goes one block down.
		if (state_q == ST_ADJ) begin
			adjx_q <= (cx_q[CAM_W-1] && (rx_q != '0)) ? (bws_q - rx_q) : rx_q;
			adjz_q <= (cz_q[CAM_W-1] && (rz_q != '0)) ? (bws_q - rz_q) : rz_q;
		end
		if (state_q == ST_SNAP) begin
			sx_q  <= (bws_q == '0) ? '0 : (POS_W'(cx_q) - signed'(POS_W'(adjx_q)));
			sz_q  <= (bws_q == '0) ? '0 : (POS_W'(cz_q) - signed'(POS_W'(adjz_q)));
			emb_q <= ext - signed'(POS_W'(bws_q));
		end
	end

endmodule

// File: src/crbe_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbe_cmd_queue: short command queue between front and back end
// A small register FIFO that lets the divider and the block walk stall
// independently of each other.
// ----------------------------------------------------------------------------
module crbe_cmd_queue
	import crbe_pkg::*;
#(
	parameter int DEPTH = CMD_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: src/crbe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbe_back: block walk and result emitter
// Walks the square block grid of one level, one block per cycle while the
// output is not stalled, drops the blocks covered by the finer footprint and
// holds one kept block back so that the final one can carry the level's count.
// ----------------------------------------------------------------------------
module crbe_back
	import crbe_pkg::*;
#(
	parameter int SIDE_BLOCKS = SIDE_BLOCKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic blk_valid,
	input  logic blk_stall,
	output blk_t blk
);

	localparam int HALF = SIDE_BLOCKS / 2;
	localparam int SIDE = 2 * HALF;
	localparam int XW   = (SIDE > 1) ? $clog2(SIDE) : 1;

	cmd_t                    cmd_q;
	logic                    busy_q, done_q;
	logic [XW-1:0]           col_q, row_q;
	logic signed [POS_W-1:0] ox_q, oz_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    hv_q;
	logic signed [POS_W-1:0] hx_q, hz_q;
	logic                    ov_q;
	blk_t                    o_q;

	logic o_free, cand, covered, kept, step, finish, load_o;

	// Finer footprint test, inclusive on all four sides.
	assign covered = cmd_q.skip_en && (ox_q >= cmd_q.fmin_x) && (ox_q <= cmd_q.fmax_x) &&
		(oz_q >= cmd_q.fmin_z) && (oz_q <= cmd_q.fmax_z);

	assign o_free  = !ov_q || !blk_stall;
	assign cand    = busy_q && !done_q;
	assign kept    = !covered;
	assign step    = cand && (covered || !hv_q || o_free);
	assign finish  = busy_q && done_q && (!hv_q || o_free);
	assign load_o  = (step && kept && hv_q) || (finish && hv_q);
	assign cmd_pop = !busy_q && cmd_valid;

	assign blk_valid = ov_q;
	assign blk       = o_q;

	// Walk control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			hv_q   <= 1'b0;
			ov_q   <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd_pop) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				col_q  <= '0;
				row_q  <= '0;
				cnt_q  <= '0;
			end
			if (step) begin
				if (kept) begin
					hv_q  <= 1'b1;
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (col_q == XW'(SIDE - 1)) begin
					col_q <= '0;
					if (row_q == XW'(SIDE - 1)) begin
						done_q <= 1'b1;
					end else begin
						row_q <= row_q + XW'(1);
					end
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
			if (finish) begin
				busy_q <= 1'b0;
				hv_q   <= 1'b0;
			end
			// Output register.
			if (load_o) begin
				ov_q <= 1'b1;
			end else if (!blk_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Walk positions, held block and output beat.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
			ox_q  <= cmd.start_x;
			oz_q  <= cmd.start_z;
		end
		if (step) begin
			if (col_q == XW'(SIDE - 1)) begin
				ox_q <= cmd_q.start_x;
				oz_q <= oz_q + cmd_q.bws;
			end else begin
				ox_q <= ox_q + cmd_q.bws;
			end
			if (kept) begin
				hx_q <= ox_q;
				hz_q <= oz_q;
			end
		end
		if (load_o) begin
			o_q.offset_x          <= hx_q[OFS_W-1:0];
			o_q.offset_z          <= hz_q[OFS_W-1:0];
			o_q.block_scale       <= cmd_q.scale;
			o_q.out_level         <= cmd_q.level;
			o_q.last              <= finish;
			o_q.level_block_count <= finish ? cnt_q : '0;
		end
	end

endmodule

// File: src/clipmap_ring_block_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipmap_ring_block_emitter: clipmap ring block selection
// Snaps a camera position to a level's block grid and emits every block of
// the surrounding square that is not covered by the finer level's footprint.
//
//   channel  handshake                  beat
//   item     item_valid / item_stall    item_t (cam_x, cam_z, level)
//   blk      blk_valid / blk_stall      blk_t (offsets, scale, level, last, count)
//   config   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// The front end takes one item at a time, through a 32-step remainder divider,
// and holds item_stall until its command is in the queue. The back end loads
// a command, walks (2*(SIDE_BLOCKS/2))^2 blocks, one a cycle while the output
// is not stalled, and then flushes the last held block. A command queue sits
// between them, so a stalled result stream only stops the front end once the
// queue is full. Items with a level not below MAX_LEVELS are taken and dropped.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module clipmap_ring_block_emitter
	import crbe_pkg::*;
#(
	parameter int SIDE_BLOCKS = SIDE_BLOCKS_DEF,
	parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
	parameter int CMD_DEPTH   = CMD_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        blk_valid,
	input  logic        blk_stall,
	output blk_t        blk
);

	logic cmd_push, cmd_full, cmd_pop, cmd_valid;
	cmd_t cmd_wr, cmd_rd;

	// Front end: registers, snap divider, command builder.
	crbe_front #(
		.SIDE_BLOCKS (SIDE_BLOCKS),
		.MAX_LEVELS  (MAX_LEVELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cmd_push   (cmd_push),
		.cmd        (cmd_wr),
		.cmd_full   (cmd_full)
	);

	// Command queue.
	crbe_cmd_queue #(
		.DEPTH (CMD_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wr),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.valid  (cmd_valid),
		.rdata  (cmd_rd)
	);

	// Back end: block walk and emitter.
	crbe_back #(
		.SIDE_BLOCKS (SIDE_BLOCKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_rd),
		.cmd_pop   (cmd_pop),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk       (blk)
	);

endmodule
